@@ design/abrd_pkg.sv @@
// Package with the types and constants of the adaptive binary range decoder.
`timescale 1ns / 1ps

package abrd_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_HOLD
	} abrd_state_t;

	typedef struct packed {
		logic [1:0] status;
		logic       primed;
		logic [3:0] buffer_level;
		logic [7:0] symbol;
	} abrd_result_t;

	localparam logic       OP_PUSH       = 1'b0;
	localparam logic       OP_DECODE     = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DROP     = 2'd1;
	localparam logic [1:0] STAT_UNPRIMED = 2'd2;

	localparam logic [2:0]  PRIME_BYTES  = 3'd5;
	localparam logic [10:0] PROB_INIT    = 11'd1024;
	localparam logic [11:0] PROB_ONE     = 12'd2048;
	localparam int          ADAPT_SHIFT  = 5;
	localparam logic [3:0]  MAX_BITS     = 4'd8;

endpackage

@@ design/adaptive_binary_range_decoder_unit.sv @@
// Top level of the adaptive binary range decoder with bit-tree symbol decoding.
//
// Channel  Direction  Contents
// s_axis   in         tuser: op; tdata: stream_byte, tree_index, symbol_bits
// m_axis   out        tdata: symbol, buffer_level, primed, status
//
// After reset a clearing pass sets every probability to its start value, one entry a cycle,
// and no transfer is accepted until it ends. A push or a refused decode is handled in the
// idle state; a decode runs the read, multiply and update loop on the probability memory
// once for each symbol bit. One item is worked on at a time; a finished result waits in
// the output register while the next item is taken, and a second finished result stalls
// the block until the first has been transferred.
`timescale 1ns / 1ps

module adaptive_binary_range_decoder_unit
	import abrd_pkg::*;
#(
	parameter int TREE_COUNT   = 256,
	parameter int BUFFER_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // stream_byte, tree_index, symbol_bits, zero padding
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // symbol, buffer_level, primed, status, zero padding
);

	localparam int PROB_DEPTH = TREE_COUNT * 256;
	localparam int AW         = $clog2(PROB_DEPTH);
	localparam int CW         = $clog2(BUFFER_DEPTH + 1);
	localparam int PW         = $clog2(BUFFER_DEPTH);

	abrd_state_t state_q, state_d;

	logic [AW-1:0] clr_q, clr_d;
	logic [31:0]   range_q, range_d;
	logic [31:0]   code_q, code_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [2:0]    prime_q, prime_d;
	logic [PW-1:0] rd_q, rd_d;
	logic [PW-1:0] wr_q, wr_d;
	logic          out_valid_q;
	abrd_result_t  out_q;
	abrd_result_t  hold_q;

	logic [31:0]   bound_q;
	logic [10:0]   prob_q;
	logic [7:0]    tree_q;
	logic [3:0]    nbits_q;
	logic [3:0]    done_q;
	logic [7:0]    node_q;

	logic [10:0]   prob_mem [PROB_DEPTH];
	logic [10:0]   prob_rd_q;
	logic [7:0]    fifo_mem [BUFFER_DEPTH];
	logic [7:0]    fifo_rd_q;

	logic          prob_we;
	logic [AW-1:0] prob_waddr;
	logic [10:0]   prob_wdata;
	logic [AW-1:0] prob_raddr;
	logic          fifo_we;

	logic [7:0]    in_byte;
	logic [7:0]    in_tree;
	logic [3:0]    in_bits;
	logic [7:0]    tree_mod;
	logic [3:0]    nbits_clamped;

	logic          start;
	logic          finish;
	logic          out_free;
	logic          out_load;
	logic          hold_load;
	abrd_result_t  res;
	abrd_result_t  out_d;
	logic          less;
	logic [31:0]   rng;
	logic [31:0]   cod;
	logic [10:0]   prob_new;
	logic          bit_val;
	logic [8:0]    node_n;
	logic [3:0]    done_n;
	logic [7:0]    pop_byte;
	logic [7:0]    sym_mask;

	assign in_byte = s_axis_tdata[7:0];
	assign in_tree = s_axis_tdata[15:8];
	assign in_bits = s_axis_tdata[19:16];

	always_comb begin
		tree_mod = in_tree;
		for (int k = 7; k >= 0; k--) begin
			if (32'(tree_mod) >= (32'(TREE_COUNT) << k)) begin
				tree_mod = tree_mod - 8'(32'(TREE_COUNT) << k);
			end
		end
	end

	always_comb begin
		if (in_bits == 4'd0) begin
			nbits_clamped = 4'd1;
		end else if (in_bits > MAX_BITS) begin
			nbits_clamped = MAX_BITS;
		end else begin
			nbits_clamped = in_bits;
		end
	end

	always_comb begin
		less     = code_q < bound_q;
		bit_val  = ~less;
		rng      = less ? bound_q : range_q - bound_q;
		cod      = less ? code_q : code_q - bound_q;
		prob_new = less ? prob_q + 11'((PROB_ONE - {1'b0, prob_q}) >> ADAPT_SHIFT)
		                : prob_q - (prob_q >> ADAPT_SHIFT);
		node_n   = {node_q, bit_val};
		done_n   = done_q + 4'd1;
		pop_byte = (cnt_q != '0) ? fifo_rd_q : 8'd0;
		sym_mask = 8'((9'd1 << nbits_q) - 9'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		range_d    = range_q;
		code_d     = code_q;
		cnt_d      = cnt_q;
		prime_d    = prime_q;
		rd_d       = rd_q;
		wr_d       = wr_q;
		prob_we    = 1'b0;
		prob_waddr = clr_q;
		prob_wdata = PROB_INIT;
		prob_raddr = AW'({tree_q, node_q});
		fifo_we    = 1'b0;
		start      = 1'b0;
		finish     = 1'b0;
		res        = '0;
		out_load   = 1'b0;
		hold_load  = 1'b0;
		out_d      = hold_q;
		s_axis_tready = (state_q == ST_IDLE);

		unique case (state_q)
			ST_CLEAR: begin
				prob_we = 1'b1;
				if (clr_q == AW'(PROB_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (s_axis_tuser == OP_PUSH) begin
						finish     = 1'b1;
						res.status = STAT_OK;
						if (prime_q < PRIME_BYTES) begin
							if (prime_q != 3'd0) begin
								code_d = {code_q[23:0], in_byte};
							end
							prime_d = prime_q + 3'd1;
						end else if (cnt_q == CW'(BUFFER_DEPTH)) begin
							res.status = STAT_DROP;
						end else begin
							fifo_we = 1'b1;
							cnt_d   = cnt_q + CW'(1);
							wr_d    = (wr_q == PW'(BUFFER_DEPTH - 1)) ? '0 : wr_q + PW'(1);
						end
						res.buffer_level = 4'(cnt_d);
						res.primed       = (prime_d == PRIME_BYTES);
					end else if (prime_q != PRIME_BYTES) begin
						finish           = 1'b1;
						res.status       = STAT_UNPRIMED;
						res.buffer_level = 4'(cnt_q);
						res.primed       = 1'b0;
					end else begin
						start      = 1'b1;
						prob_raddr = AW'({tree_mod, 8'd1});
						state_d    = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				prob_we    = 1'b1;
				prob_waddr = AW'({tree_q, node_q});
				prob_wdata = prob_new;
				if (rng[31:24] == 8'd0) begin
					range_d = {rng[23:0], 8'h00};
					code_d  = {cod[23:0], pop_byte};
					if (cnt_q != '0) begin
						cnt_d = cnt_q - CW'(1);
						rd_d  = (rd_q == PW'(BUFFER_DEPTH - 1)) ? '0 : rd_q + PW'(1);
					end
				end else begin
					range_d = rng;
					code_d  = cod;
				end
				if (done_n == nbits_q) begin
					finish           = 1'b1;
					res.symbol       = node_n[7:0] & sym_mask;
					res.buffer_level = 4'(cnt_d);
					res.primed       = 1'b1;
					res.status       = STAT_OK;
				end else begin
					prob_raddr = AW'({tree_q, node_n[7:0]});
					state_d    = ST_MUL;
				end
			end
			ST_HOLD: begin
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		out_free = !out_valid_q || m_axis_tready;
		if (finish) begin
			if (out_free) begin
				out_load = 1'b1;
				out_d    = res;
				state_d  = ST_IDLE;
			end else begin
				hold_load = 1'b1;
				state_d   = ST_HOLD;
			end
		end else if (state_q == ST_HOLD && out_free) begin
			out_load = 1'b1;
			out_d    = hold_q;
			state_d  = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			range_q     <= 32'hFFFF_FFFF;
			code_q      <= '0;
			cnt_q       <= '0;
			prime_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			clr_q   <= clr_d;
			range_q <= range_d;
			code_q  <= code_d;
			cnt_q   <= cnt_d;
			prime_q <= prime_d;
			rd_q    <= rd_d;
			wr_q    <= wr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		bound_q <= {11'd0, range_q[31:11]} * {21'd0, prob_rd_q};
		prob_q  <= prob_rd_q;
		if (start) begin
			tree_q  <= tree_mod;
			nbits_q <= nbits_clamped;
			node_q  <= 8'd1;
			done_q  <= 4'd0;
		end else if (state_q == ST_UPD) begin
			node_q <= node_n[7:0];
			done_q <= done_n;
		end
		if (hold_load) begin
			hold_q <= res;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk) begin
		if (prob_we) begin
			prob_mem[prob_waddr] <= prob_wdata;
		end
		prob_rd_q <= prob_mem[prob_raddr];
	end

	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_mem[wr_q] <= in_byte;
		end
		fifo_rd_q <= fifo_mem[rd_q];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q};

endmodule
